FILE: hw/rtl/json_byte_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// json_byte_tokenizer_assert.svh
// Assertion macros used by the tokenizer checker.
// ----------------------------------------------------------------------------
`ifndef JSON_BYTE_TOKENIZER_ASSERT_SVH
`define JSON_BYTE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JBT_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("jbt: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define JBT_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("jbt: next-cycle property failed");

`endif

FILE: hw/rtl/jbt_pkg.sv
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared constants, codes and lookup functions of the JSON byte tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package jbt_pkg;

	localparam int ROW_BITS_DEF = 24;
	localparam int COL_BITS_DEF = 16;
	localparam int LEN_BITS_DEF = 16;

	localparam int BYTE_W = 8;
	localparam int KIND_W = 4;

	// Result queue depth; a power of two, at least two.
	localparam int Q_DEPTH = 4;

	// Lexer modes.
	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_STR  = 3'd1;
	localparam logic [2:0] MODE_NUM  = 3'd2;
	localparam logic [2:0] MODE_LIT  = 3'd3;
	localparam logic [2:0] MODE_ERR  = 3'd4;

	// Token kinds.
	localparam logic [3:0] K_END    = 4'd0;
	localparam logic [3:0] K_LBRACE = 4'd1;
	localparam logic [3:0] K_RBRACE = 4'd2;
	localparam logic [3:0] K_LBRACK = 4'd3;
	localparam logic [3:0] K_RBRACK = 4'd4;
	localparam logic [3:0] K_COLON  = 4'd5;
	localparam logic [3:0] K_COMMA  = 4'd6;
	localparam logic [3:0] K_STRING = 4'd7;
	localparam logic [3:0] K_INT    = 4'd8;
	localparam logic [3:0] K_FLOAT  = 4'd9;
	localparam logic [3:0] K_TRUE   = 4'd10;
	localparam logic [3:0] K_ERROR  = 4'd13;

	// Literal kinds.
	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	// Characters.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UPPER_E = 8'h45;
	localparam logic [7:0] CH_LOWER_E = 8'h65;
	localparam logic [7:0] CH_LOWER_T = 8'h74;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_LOWER_N = 8'h6E;
	localparam logic [7:0] CH_LOWER_R = 8'h72;
	localparam logic [7:0] CH_LOWER_U = 8'h75;
	localparam logic [7:0] CH_LOWER_L = 8'h6C;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_S = 8'h73;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	// Token kind of a punctuation byte, K_END when the byte is not punctuation.
	function automatic logic [3:0] punct_kind(input logic [7:0] ch);
		logic [3:0] k;
		case (ch)
			CH_LBRACE: k = K_LBRACE;
			CH_RBRACE: k = K_RBRACE;
			CH_LBRACK: k = K_LBRACK;
			CH_RBRACK: k = K_RBRACK;
			CH_COLON:  k = K_COLON;
			CH_COMMA:  k = K_COMMA;
			default:   k = K_END;
		endcase
		return k;
	endfunction

	// Number of characters in a literal; zero for an unused kind code.
	function automatic logic [2:0] lit_len(input logic [1:0] lk);
		logic [2:0] n;
		case (lk)
			LIT_TRUE:  n = 3'd4;
			LIT_FALSE: n = 3'd5;
			LIT_NULL:  n = 3'd4;
			default:   n = 3'd0;
		endcase
		return n;
	endfunction

	// Expected character of a literal at a position.
	function automatic logic [7:0] lit_char(input logic [1:0] lk, input logic [2:0] lp);
		logic [7:0] c;
		c = 8'h00;
		case (lk)
			LIT_TRUE: begin
				case (lp)
					3'd0:    c = CH_LOWER_T;
					3'd1:    c = CH_LOWER_R;
					3'd2:    c = CH_LOWER_U;
					3'd3:    c = CH_LOWER_E;
					default: c = 8'h00;
				endcase
			end
			LIT_FALSE: begin
				case (lp)
					3'd0:    c = CH_LOWER_F;
					3'd1:    c = CH_LOWER_A;
					3'd2:    c = CH_LOWER_L;
					3'd3:    c = CH_LOWER_S;
					3'd4:    c = CH_LOWER_E;
					default: c = 8'h00;
				endcase
			end
			LIT_NULL: begin
				case (lp)
					3'd0:    c = CH_LOWER_N;
					3'd1:    c = CH_LOWER_U;
					3'd2:    c = CH_LOWER_L;
					3'd3:    c = CH_LOWER_L;
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/json_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// json_byte_tokenizer
// Streaming JSON lexer taking one text byte per transfer.
// ----------------------------------------------------------------------------
//   channel   direction  payload
//   s_*       in         tdata: in_byte; tlast: end_of_input
//   m_*       out        tdata: content_byte, token_kind, row, col, length;
//                        tuser: item_kind; tlast: last result of the byte
//
// One byte is taken per cycle while the result queue has room; the lexer
// state updates in a single pass from the input register and its results
// enter a four-entry result queue.
// Bytes that give two results need two output transfers; the queue absorbs them.
// s_tready depends only on registered state, never on m_tready.
// Reset is asynchronous and restores line 1, column 1, idle mode.
// ----------------------------------------------------------------------------
`default_nettype none

module json_byte_tokenizer
	import jbt_pkg::*;
#(
	parameter int ROW_BITS = ROW_BITS_DEF,
	parameter int COL_BITS = COL_BITS_DEF,
	parameter int LEN_BITS = LEN_BITS_DEF,
	parameter int TDATA_W  =
		((BYTE_W + KIND_W + ROW_BITS + COL_BITS + LEN_BITS + 7) / 8) * 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // [7:0] in_byte
	input  wire logic               s_tlast,   // end_of_input
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// content_byte, token_kind, token_row, token_col, token_length, zero fill
	output logic [TDATA_W-1:0]      m_tdata,
	output logic                    m_tuser,   // item_kind
	output logic                    m_tlast    // last
);

	localparam int ENT_W = 2 + BYTE_W + KIND_W + ROW_BITS + COL_BITS + LEN_BITS;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eoi_s1;
	logic             room;
	logic             advance;
	logic             s_xfer;
	logic [1:0]       res_cnt;
	logic [1:0]       wr_cnt;
	logic [ENT_W-1:0] res0;
	logic [ENT_W-1:0] res1;
	logic [ENT_W-1:0] head;

	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || room;
	assign s_xfer   = s_tvalid && s_tready;
	assign wr_cnt   = advance ? res_cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	jbt_lexer #(
		.ROW_BITS (ROW_BITS),
		.COL_BITS (COL_BITS),
		.LEN_BITS (LEN_BITS),
		.ENT_W    (ENT_W)
	) u_lexer (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.in_byte      (byte_s1),
		.end_of_input (eoi_s1),
		.res_cnt      (res_cnt),
		.res0         (res0),
		.res1         (res1)
	);

	jbt_res_queue #(
		.W     (ENT_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_cnt    (wr_cnt),
		.wr0       (res0),
		.wr1       (res1),
		.rd        (m_tvalid && m_tready),
		.head      (head),
		.not_empty (m_tvalid),
		.room      (room)
	);

	assign m_tdata = TDATA_W'(head[ENT_W-1:2]);
	assign m_tuser = head[1];
	assign m_tlast = head[0];

endmodule

`default_nettype wire

FILE: hw/rtl/jbt_res_queue.sv
// ----------------------------------------------------------------------------
// jbt_res_queue
// Small result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jbt_res_queue
	import jbt_pkg::*;
#(
	parameter int W     = 64,
	parameter int DEPTH = Q_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [1:0]   wr_cnt,
	input  wire logic [W-1:0] wr0,
	input  wire logic [W-1:0] wr1,
	input  wire logic         rd,
	output logic [W-1:0]      head,
	output logic              not_empty,
	output logic              room
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wptr_p1;

	assign wptr_p1   = wptr_q + PTR_W'(1);
	assign head      = mem_q[rptr_q];
	assign not_empty = (count_q != '0);
	// Room for a full pair of results, judged on registered state only.
	assign room      = (count_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PTR_W'(wr_cnt);
			rptr_q  <= rptr_q + PTR_W'(rd);
			count_q <= count_q + CNT_W'(wr_cnt) - CNT_W'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) begin
			mem_q[wptr_q] <= wr0;
		end
		if (wr_cnt == 2'd2) begin
			mem_q[wptr_p1] <= wr1;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/jbt_lexer.sv
// ----------------------------------------------------------------------------
// jbt_lexer
// Lexer state and the single-pass next-state and result logic for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jbt_lexer
	import jbt_pkg::*;
#(
	parameter int ROW_BITS = ROW_BITS_DEF,
	parameter int COL_BITS = COL_BITS_DEF,
	parameter int LEN_BITS = LEN_BITS_DEF,
	parameter int ENT_W    = 2 + BYTE_W + KIND_W + ROW_BITS + COL_BITS + LEN_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic [7:0]       in_byte,
	input  wire logic             end_of_input,
	output logic [1:0]            res_cnt,
	output logic [ENT_W-1:0]      res0,
	output logic [ENT_W-1:0]      res1
);

	logic [2:0]          mode_q,  nx_mode;
	logic [ROW_BITS-1:0] line_q,  nx_line;
	logic [COL_BITS-1:0] col_q,   nx_col;
	logic [COL_BITS-1:0] start_q, nx_start;
	logic [LEN_BITS-1:0] len_q,   nx_len;
	logic                point_q, nx_point;
	logic [1:0]          lkind_q, nx_lkind;
	logic [2:0]          lpos_q,  nx_lpos;

	logic [ENT_W-1:0]    r [2];
	logic [1:0]          n;

	function automatic logic [COL_BITS-1:0] col_inc(input logic [COL_BITS-1:0] v);
		return (&v) ? v : v + COL_BITS'(1);
	endfunction

	function automatic logic [ROW_BITS-1:0] row_inc(input logic [ROW_BITS-1:0] v);
		return (&v) ? v : v + ROW_BITS'(1);
	endfunction

	function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] v);
		return (&v) ? v : v + LEN_BITS'(1);
	endfunction

	// Result entry, low bit first: last, item kind, content byte, token kind,
	// row, column, length. The last flag is filled in afterwards.
	function automatic logic [ENT_W-1:0] mk(input logic ik, input logic [7:0] cb,
			input logic [3:0] tk, input logic [ROW_BITS-1:0] row,
			input logic [COL_BITS-1:0] col, input logic [LEN_BITS-1:0] len);
		return {len, col, row, tk, cb, ik, 1'b0};
	endfunction

	always_comb begin
		logic       do_idle;
		logic [3:0] pk;
		logic [3:0] lp_next;
		nx_mode  = mode_q;
		nx_line  = line_q;
		nx_col   = col_q;
		nx_start = start_q;
		nx_len   = len_q;
		nx_point = point_q;
		nx_lkind = lkind_q;
		nx_lpos  = lpos_q;
		r[0]     = '0;
		r[1]     = '0;
		n        = 2'd0;
		do_idle  = 1'b0;
		pk       = punct_kind(in_byte);
		lp_next  = {1'b0, lpos_q} + 4'd1;

		if (mode_q >= MODE_ERR) begin
			// Sticky error: nothing more until reset.
			n = 2'd0;
		end else if (end_of_input) begin
			if (mode_q == MODE_LIT) begin
				r[n[0]] = mk(1'b1, 8'h00, K_ERROR, line_q, col_q, '0);
				n = n + 2'd1;
				nx_mode = MODE_ERR;
			end else begin
				if (mode_q == MODE_STR) begin
					r[n[0]] = mk(1'b1, 8'h00, K_STRING, line_q, start_q, len_q);
					n = n + 2'd1;
				end else if (mode_q == MODE_NUM) begin
					r[n[0]] = mk(1'b1, 8'h00, point_q ? K_FLOAT : K_INT, line_q,
						start_q, len_q);
					n = n + 2'd1;
				end
				r[n[0]] = mk(1'b1, 8'h00, K_END, line_q, '0, '0);
				n = n + 2'd1;
				nx_mode  = MODE_IDLE;
				nx_line  = ROW_BITS'(1);
				nx_col   = COL_BITS'(1);
				nx_start = '0;
				nx_len   = '0;
				nx_point = 1'b0;
				nx_lkind = LIT_TRUE;
				nx_lpos  = '0;
			end
		end else begin
			case (mode_q)
				MODE_STR: begin
					nx_col = col_inc(col_q);
					if (in_byte == CH_QUOTE) begin
						r[n[0]] = mk(1'b1, 8'h00, K_STRING, line_q, start_q, len_q);
						n = n + 2'd1;
						nx_mode = MODE_IDLE;
					end else begin
						r[n[0]] = mk(1'b0, in_byte, K_END, '0, '0, '0);
						n = n + 2'd1;
						nx_len = len_inc(len_q);
					end
				end
				MODE_NUM: begin
					if (in_byte inside {[CH_0:CH_9], CH_MINUS, CH_PLUS, CH_POINT,
							CH_UPPER_E, CH_LOWER_E}) begin
						r[n[0]] = mk(1'b0, in_byte, K_END, '0, '0, '0);
						n = n + 2'd1;
						if (in_byte == CH_POINT) begin
							nx_point = 1'b1;
						end
						nx_len = len_inc(len_q);
						nx_col = col_inc(col_q);
					end else begin
						// The terminating byte is lexed again in idle mode.
						r[n[0]] = mk(1'b1, 8'h00, point_q ? K_FLOAT : K_INT, line_q,
							start_q, len_q);
						n = n + 2'd1;
						nx_mode = MODE_IDLE;
						do_idle = 1'b1;
					end
				end
				MODE_LIT: begin
					if (lkind_q == 2'd3 || lpos_q >= lit_len(lkind_q) ||
							lit_char(lkind_q, lpos_q) != in_byte) begin
						r[n[0]] = mk(1'b1, 8'h00, K_ERROR, line_q, col_q, '0);
						n = n + 2'd1;
						nx_mode = MODE_ERR;
					end else begin
						nx_col  = col_inc(col_q);
						nx_lpos = lp_next[2:0];
						if (lp_next == {1'b0, lit_len(lkind_q)}) begin
							r[n[0]] = mk(1'b1, 8'h00, K_TRUE + {2'b00, lkind_q}, line_q,
								start_q, '0);
							n = n + 2'd1;
							nx_mode = MODE_IDLE;
						end
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase
		end

		if (do_idle) begin
			if (in_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
				nx_col = col_inc(col_q);
				if (in_byte == CH_LF) begin
					nx_line = row_inc(line_q);
					nx_col  = COL_BITS'(1);
				end
			end else if (pk != K_END) begin
				r[n[0]] = mk(1'b1, 8'h00, pk, line_q, col_q, '0);
				n = n + 2'd1;
				nx_col = col_inc(col_q);
			end else if (in_byte == CH_QUOTE) begin
				nx_start = col_q;
				nx_len   = '0;
				nx_col   = col_inc(col_q);
				nx_mode  = MODE_STR;
			end else if (in_byte inside {[CH_0:CH_9], CH_MINUS, CH_PLUS}) begin
				nx_start = col_q;
				nx_len   = LEN_BITS'(1);
				nx_point = 1'b0;
				r[n[0]] = mk(1'b0, in_byte, K_END, '0, '0, '0);
				n = n + 2'd1;
				nx_col   = col_inc(col_q);
				nx_mode  = MODE_NUM;
			end else if (in_byte inside {CH_LOWER_T, CH_LOWER_F, CH_LOWER_N}) begin
				nx_start = col_q;
				nx_lkind = (in_byte == CH_LOWER_T) ? LIT_TRUE :
					((in_byte == CH_LOWER_F) ? LIT_FALSE : LIT_NULL);
				nx_lpos  = 3'd1;
				nx_col   = col_inc(col_q);
				nx_mode  = MODE_LIT;
			end else begin
				r[n[0]] = mk(1'b1, 8'h00, K_ERROR, line_q, col_q, '0);
				n = n + 2'd1;
				nx_mode = MODE_ERR;
			end
		end

		if (n == 2'd1) begin
			r[0][0] = 1'b1;
		end else if (n == 2'd2) begin
			r[1][0] = 1'b1;
		end
	end

	assign res_cnt = n;
	assign res0    = r[0];
	assign res1    = r[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			line_q  <= ROW_BITS'(1);
			col_q   <= COL_BITS'(1);
			start_q <= '0;
			len_q   <= '0;
			point_q <= 1'b0;
			lkind_q <= LIT_TRUE;
			lpos_q  <= '0;
		end else if (advance) begin
			mode_q  <= nx_mode;
			line_q  <= nx_line;
			col_q   <= nx_col;
			start_q <= nx_start;
			len_q   <= nx_len;
			point_q <= nx_point;
			lkind_q <= nx_lkind;
			lpos_q  <= nx_lpos;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/jbt_chk.sv
// ----------------------------------------------------------------------------
// jbt_chk
// Port-level checks on the tokenizer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_byte_tokenizer_assert.svh"

module jbt_chk
	import jbt_pkg::*;
#(
	parameter int ROW_BITS = ROW_BITS_DEF,
	parameter int COL_BITS = COL_BITS_DEF,
	parameter int LEN_BITS = LEN_BITS_DEF,
	parameter int TDATA_W  =
		((BYTE_W + KIND_W + ROW_BITS + COL_BITS + LEN_BITS + 7) / 8) * 8
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [TDATA_W-1:0] m_tdata,
	input wire logic               m_tuser,
	input wire logic               m_tlast
);

	localparam int KIND_LO = BYTE_W;
	localparam int COL_LO  = BYTE_W + KIND_W + ROW_BITS;
	localparam int LEN_LO  = COL_LO + COL_BITS;

	// A stalled result holds still.
	`JBT_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// A content byte is always the only result of its byte and has no token fields.
	`JBT_ASSERT_IMP(a_content, clk, arst_n, m_tvalid && !m_tuser,
		m_tlast && (m_tdata[TDATA_W-1:BYTE_W] == '0))

	// A token record carries no content byte and a defined kind.
	`JBT_ASSERT_IMP(a_record, clk, arst_n, m_tvalid && m_tuser,
		(m_tdata[BYTE_W-1:0] == '0) && (m_tdata[KIND_LO+KIND_W-1:KIND_LO] <= K_ERROR))

	// The end token closes its byte's results and has no column or length.
	`JBT_ASSERT_IMP(a_end, clk, arst_n,
		m_tvalid && m_tuser && (m_tdata[KIND_LO+KIND_W-1:KIND_LO] == K_END),
		m_tlast && (m_tdata[LEN_LO-1:COL_LO] == '0) &&
		(m_tdata[LEN_LO+LEN_BITS-1:LEN_LO] == '0))

endmodule

bind json_byte_tokenizer jbt_chk #(
	.ROW_BITS (ROW_BITS),
	.COL_BITS (COL_BITS),
	.LEN_BITS (LEN_BITS),
	.TDATA_W  (TDATA_W)
) u_jbt_chk (.*);

`default_nettype wire
